[sv/lbp3u_pkg.sv]
`timescale 1ns / 1ps

package lbp3u_pkg;

   // widest row the line stores hold
   localparam int MAX_WIDTH = 1024;

   localparam int PIX_W   = 8;
   localparam int FW_W    = 11;
   localparam int FH_W    = 16;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 2;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int LIM_W   = (FW_W > $clog2(MAX_WIDTH + 1)) ? FW_W : $clog2(MAX_WIDTH + 1);
   localparam int IN_ROW_W  = FH_W + 1;
   localparam int OUT_ROW_W = FH_W;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] CSR_CODE_MODE    = 2'd2;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

   localparam logic MODE_BASIC   = 1'b0;
   localparam logic MODE_UNIFORM = 1'b1;

   localparam logic [PIX_W-1:0] ZERO_MARK = 8'd255;

   typedef logic [PIX_W-1:0] bin_table_type [256];

   function automatic int hop_count(input int c);
      int r;
      int x;
      int n;
      r = ((c << 1) | (c >> 7)) & 8'hFF;
      x = (c ^ r) & 8'hFF;
      n = 0;
      for (int i = 0; i < 8; i++) begin
         n += (x >> i) & 1;
      end
      return n;
   endfunction

   // rank of each code among codes with at most two circular hops, 0 otherwise
   function automatic bin_table_type build_uniform_bin();
      bin_table_type tbl;
      int rank;
      rank = 1;
      for (int c = 0; c < 256; c++) begin
         if (hop_count(c) <= 2) begin
            tbl[c] = PIX_W'(rank);
            rank++;
         end else begin
            tbl[c] = '0;
         end
      end
      return tbl;
   endfunction

   localparam bin_table_type UNIFORM_BIN = build_uniform_bin();

endpackage

[sv/lbp_3x3_uniform_code.sv]
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_kind, req_pixel
// rsp       out        rsp_valid / rsp_ready  rsp_code, rsp_frame_last
// csr       in         csr_we (no wait)       csr_index, csr_data
//
// One beat per clock: the 3x3 code is formed in one pass between the line store
// read register and the result register. The line stores are read one column
// ahead; after a csr write that moves the input column, or when a beat writes the
// column that is read next (the beat that closes a frame), req_ready drops for
// one cycle while that column is read again.
// Reset (synchronous) restores register defaults and clears counters and window;
// line store contents stay undefined. req_ready stays low in the first cycle after
// reset while column 0 is read. A stalled rsp beat holds; a new req beat is
// taken in the same cycle the waiting result is taken.

module lbp_3x3_uniform_code
   import lbp3u_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [PIX_W-1:0] req_pixel,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_code,
   output logic             rsp_frame_last,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   localparam logic [IN_ROW_W-1:0]  IN_ROW_MAX  = '1;
   localparam logic [OUT_ROW_W-1:0] OUT_ROW_MAX = '1;

   // configuration
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;
   logic            code_mode_ff;

   // line stores and their prefetch
   logic [PIX_W-1:0] line_store_a_ff [MAX_WIDTH];
   logic [PIX_W-1:0] line_store_b_ff [MAX_WIDTH];
   logic [PIX_W-1:0] rd_a_ff, rd_b_ff;
   logic [COL_W-1:0] rd_addr_ff, rd_addr_in;
   logic             rd_ok_ff, rd_ok_in;

   // window [column oldest..newest][row top..bottom]
   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] win_in [3][3];

   // position counters
   logic [COL_W-1:0]     in_column_ff, in_column_in;
   logic [IN_ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]     out_column_ff, out_column_in;
   logic [OUT_ROW_W-1:0] out_row_ff, out_row_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_code_ff, rsp_code_in;
   logic             rsp_frame_last_ff, rsp_frame_last_in;

   logic [LIM_W-1:0]    w_lim;
   logic [FH_W-1:0]     h_lim;
   logic                col_wrap;
   logic [COL_W-1:0]    eff_col;
   logic [IN_ROW_W-1:0] eff_row;
   logic                draining, ignored, due, accept, write_en, load, last;
   logic [PIX_W-1:0]    value;
   logic [LIM_W-1:0]    col_inc, out_col_inc;
   logic [COL_W-1:0]    col_next;
   logic [IN_ROW_W-1:0] row_next;
   logic [1:0]          lc, rc, tr, br;
   logic [PIX_W-1:0]    p [9];
   logic [PIX_W-1:0]    centre, raw_code, code_sel;
   logic [3:0]          zeros;

   // clamp the frame size
   always_comb begin
      if (frame_width_ff < FW_W'(2)) begin
         w_lim = LIM_W'(2);
      end else if (LIM_W'(frame_width_ff) > LIM_W'(MAX_WIDTH)) begin
         w_lim = LIM_W'(MAX_WIDTH);
      end else begin
         w_lim = LIM_W'(frame_width_ff);
      end
      h_lim = (frame_height_ff < FH_W'(2)) ? FH_W'(2) : frame_height_ff;
   end

   // column counter left past a shrunk width wraps to the next row first
   assign col_wrap = LIM_W'(in_column_ff) >= w_lim;
   assign eff_col  = col_wrap ? '0 : in_column_ff;
   assign eff_row  = (col_wrap && in_row_ff != IN_ROW_MAX) ? in_row_ff + 1'b1 : in_row_ff;

   assign draining = eff_row >= IN_ROW_W'(h_lim);
   assign ignored  = !draining && req_kind;
   assign value    = draining ? '0 : req_pixel;
   assign due      = (eff_row >= IN_ROW_W'(2)) ||
                     (eff_row == IN_ROW_W'(1) && eff_col != '0);

   assign req_ready = rd_ok_ff && (rd_addr_ff == eff_col) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign write_en  = accept && !ignored;
   assign load      = write_en && due;

   assign col_inc  = LIM_W'(eff_col) + 1'b1;
   assign col_next = (col_inc >= w_lim) ? '0 : col_inc[COL_W-1:0];
   assign row_next = (col_inc >= w_lim && eff_row != IN_ROW_MAX) ? eff_row + 1'b1 : eff_row;

   // shift the window: newest column comes from the line stores and the beat
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[0][r] = win_ff[1][r];
         win_in[1][r] = win_ff[2][r];
      end
      win_in[2][0] = rd_a_ff;
      win_in[2][1] = rd_b_ff;
      win_in[2][2] = value;
   end

   // mirror at the borders; at column 0 the previous row's last pixel is scored
   always_comb begin
      if (eff_col == '0) begin
         lc = 2'd0;
         rc = 2'd0;
      end else begin
         lc = (out_column_ff == '0) ? 2'd2 : 2'd0;
         rc = (LIM_W'(out_column_ff) + 1'b1 >= w_lim) ? lc : 2'd2;
      end
      tr = (out_row_ff == '0) ? 2'd2 : 2'd0;
      br = (IN_ROW_W'(out_row_ff) + 1'b1 >= IN_ROW_W'(h_lim)) ? 2'd0 : 2'd2;
   end

   always_comb begin
      centre = win_in[1][1];
      p[0] = win_in[lc][tr];
      p[1] = win_in[1][tr];
      p[2] = win_in[rc][tr];
      p[3] = win_in[rc][1];
      p[4] = win_in[rc][br];
      p[5] = win_in[1][br];
      p[6] = win_in[lc][br];
      p[7] = win_in[lc][1];
      p[8] = centre;
      zeros = '0;
      for (int i = 0; i < 8; i++) begin
         raw_code[7-i] = p[i] >= centre;
      end
      for (int i = 0; i < 9; i++) begin
         zeros = zeros + 4'(p[i] == '0);
      end
      if (code_mode_ff == MODE_BASIC) begin
         code_sel = raw_code;
      end else if (zeros >= 4'd3) begin
         code_sel = ZERO_MARK;
      end else begin
         code_sel = UNIFORM_BIN[raw_code];
      end
   end

   assign out_col_inc = LIM_W'(out_column_ff) + 1'b1;
   assign last = (IN_ROW_W'(out_row_ff) + 1'b1 >= IN_ROW_W'(h_lim)) && (out_col_inc >= w_lim);

   // advance counters
   always_comb begin
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (accept) begin
         if (ignored) begin
            in_column_in = eff_col;
            in_row_in    = eff_row;
         end else begin
            in_column_in = col_next;
            in_row_in    = row_next;
            if (due) begin
               if (last) begin
                  in_column_in  = '0;
                  in_row_in     = '0;
                  out_column_in = '0;
                  out_row_in    = '0;
               end else if (out_col_inc >= w_lim) begin
                  out_column_in = '0;
                  out_row_in    = (out_row_ff != OUT_ROW_MAX) ? out_row_ff + 1'b1 : out_row_ff;
               end else begin
                  out_column_in = out_col_inc[COL_W-1:0];
               end
            end
         end
      end
   end

   // read one column ahead; re-read if this beat writes that same column
   assign rd_addr_in = accept ? in_column_in : eff_col;
   assign rd_ok_in   = !(write_en && rd_addr_in == eff_col);

   assign rsp_code_in       = load ? code_sel : rsp_code_ff;
   assign rsp_frame_last_in = load ? last : rsp_frame_last_ff;
   assign rsp_valid_in      = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (write_en) begin
         line_store_a_ff[eff_col] <= rd_b_ff;
         line_store_b_ff[eff_col] <= value;
      end
      rd_a_ff    <= line_store_a_ff[rd_addr_in];
      rd_b_ff    <= line_store_b_ff[rd_addr_in];
      rd_addr_ff <= rd_addr_in;
   end

   always_ff @(posedge clock) begin
      rsp_code_ff       <= rsp_code_in;
      rsp_frame_last_ff <= rsp_frame_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         code_mode_ff    <= MODE_BASIC;
         in_column_ff    <= '0;
         in_row_ff       <= '0;
         out_column_ff   <= '0;
         out_row_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         rd_ok_ff        <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[c][r] <= '0;
            end
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[FW_W-1:0];
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FH_W-1:0];
               CSR_CODE_MODE:    code_mode_ff    <= csr_data[0];
               default: ;
            endcase
         end
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_ok_ff      <= rd_ok_in;
         if (write_en) begin
            win_ff <= win_in;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code       = rsp_code_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

endmodule

[test/lbp_3x3_uniform_code_tb.sv]
`timescale 1ns / 1ps

module lbp_3x3_uniform_code_tb;
   import lbp3u_pkg::*;

   // index 3 decodes to no register; writes there must change nothing
   localparam logic [IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int SETTLE_CYCLES = 8;     // pipeline slack before a csr write
   localparam int TAIL_CYCLES   = 32;    // quiet time after the last result
   localparam int QUIET_LIMIT   = 4000;  // cycles with no beat on either channel
   localparam int HOLD_AT       = 120;   // result count that triggers the long stall
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_BEATS  = 250;
   localparam int WIDE_BEATS    = MAX_WIDTH + 6;  // one full clamped row and a bit

   typedef enum int {MIX_FULL, MIX_LOW, MIX_SPARSE_ZERO, MIX_FLAT} pixel_mix_type;
   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} stall_pattern_type;

   typedef struct {
      logic [PIX_W-1:0] code;
      logic             frame_last;
   } code_beat_type;

   // Tracks the line stores, the 3x3 window and the in/out raster counters, and
   // queues the code that each accepted beat releases.
   class code_scoreboard;
      logic [FW_W-1:0]  width_reg;
      logic [FH_W-1:0]  height_reg;
      logic             mode_reg;
      logic [PIX_W-1:0] row_top [MAX_WIDTH];
      logic [PIX_W-1:0] row_mid [MAX_WIDTH];
      logic [PIX_W-1:0] win [3][3];    // [column oldest..newest][row top..bottom]
      logic [PIX_W-1:0] bin_of [256];
      int unsigned      in_col, in_row, out_col, out_row;
      code_beat_type    pending_codes[$];
      int               fail_count;

      function new();
         int rank;
         int hops;
         logic [7:0] pat;
         width_reg  = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         mode_reg   = MODE_BASIC;
         foreach (row_top[i]) begin
            row_top[i] = '0;
            row_mid[i] = '0;
         end
         foreach (win[c, r]) win[c][r] = '0;
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         fail_count = 0;
         // rank codes with at most two circular hops, ascending from 1
         rank = 0;
         for (int c = 0; c < 256; c++) begin
            pat = 8'(c);
            hops = 0;
            for (int i = 0; i < 8; i++) hops += (pat[i] != pat[(i + 1) % 8]);
            if (hops <= 2) begin
               rank++;
               bin_of[c] = 8'(rank);
            end else begin
               bin_of[c] = '0;
            end
         end
      endfunction

      function int unsigned eff_width();
         int unsigned w;
         w = width_reg;
         if (w < 2) w = 2;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w;
      endfunction

      function int unsigned eff_height();
         int unsigned h;
         h = height_reg;
         if (h < 2) h = 2;
         return h;
      endfunction

      function void set_register(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_FRAME_WIDTH:  width_reg = data[FW_W-1:0];
            CSR_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
            CSR_CODE_MODE:    mode_reg = data[0];
            default: ;
         endcase
      endfunction

      // true once every pixel of the current frame is in (next beat drains)
      function bit pixels_done();
         int unsigned row;
         row = in_row;
         if (in_col >= eff_width()) row++;
         return row >= eff_height();
      endfunction

      function int outstanding();
         return pending_codes.size();
      endfunction

      function logic [PIX_W-1:0] window_code(int lc, int cc, int rc, int unsigned h);
         int tr;
         int br;
         int zeros;
         logic [PIX_W-1:0] p [9];
         logic [PIX_W-1:0] ctr;
         logic [7:0] pat;
         // mirror the missing row at the top and bottom edges
         tr = (out_row == 0) ? 2 : 0;
         br = (out_row + 1 >= h) ? 0 : 2;
         p[0] = win[lc][tr];
         p[1] = win[cc][tr];
         p[2] = win[rc][tr];
         p[3] = win[rc][1];
         p[4] = win[rc][br];
         p[5] = win[cc][br];
         p[6] = win[lc][br];
         p[7] = win[lc][1];
         ctr = win[cc][1];
         p[8] = ctr;
         for (int i = 0; i < 8; i++) pat[7 - i] = (p[i] >= ctr);
         if (mode_reg == MODE_BASIC) return pat;
         zeros = 0;
         for (int i = 0; i < 9; i++) zeros += (p[i] == 0);
         if (zeros >= 3) return ZERO_MARK;
         return bin_of[pat];
      endfunction

      // returns 1 when the beat releases the frame's final code
      function bit take_beat(logic kind, logic [PIX_W-1:0] pix);
         int unsigned w;
         int unsigned h;
         int unsigned x;
         int lc;
         int rc;
         bit draining;
         bit due;
         bit closing;
         logic [PIX_W-1:0] sample;
         logic [PIX_W-1:0] top;
         logic [PIX_W-1:0] mid;
         logic [PIX_W-1:0] code;
         code_beat_type beat;
         w = eff_width();
         h = eff_height();
         sample = pix;
         if (in_col >= w) begin
            in_col = 0;
            if (in_row < 17'h1FFFF) in_row++;
         end
         draining = (in_row >= h);
         if (!draining && kind) return 0;
         if (draining) sample = '0;
         x = in_col;
         due = (in_row >= 2) || (in_row == 1 && x >= 1);
         code = '0;
         // the first column of a row closes out the right edge of the row above
         if (due && x == 0) code = window_code(1, 2, 1, h);
         top = row_top[x];
         mid = row_mid[x];
         row_top[x] = mid;
         row_mid[x] = sample;
         for (int c = 0; c < 2; c++)
            for (int r = 0; r < 3; r++) win[c][r] = win[c + 1][r];
         win[2][0] = top;
         win[2][1] = mid;
         win[2][2] = sample;
         if (due && x >= 1) begin
            lc = (out_col == 0) ? 2 : 0;
            rc = (out_col + 1 >= w) ? lc : 2;
            code = window_code(lc, 1, rc, h);
         end
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            if (in_row < 17'h1FFFF) in_row++;
         end
         if (!due) return 0;
         closing = (out_row + 1 >= h) && (out_col + 1 >= w);
         beat.code = code;
         beat.frame_last = closing;
         pending_codes.push_back(beat);
         if (closing) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
         end else begin
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               if (out_row < 16'hFFFF) out_row++;
            end
         end
         return closing;
      endfunction

      function void check_beat(logic [PIX_W-1:0] code, logic frame_last);
         code_beat_type want;
         if (pending_codes.size() == 0) begin
            $error("unexpected result beat: code %0d frame_last %0b", code, frame_last);
            fail_count++;
            return;
         end
         want = pending_codes.pop_front();
         if (code !== want.code) begin
            $error("code: expected %0d, got %0d", want.code, code);
            fail_count++;
         end
         if (frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last, frame_last);
            fail_count++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_kind = 1'b0;
   logic [PIX_W-1:0] req_pixel = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [PIX_W-1:0] rsp_code;
   logic             rsp_frame_last;
   logic             csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   code_scoreboard sb = new();

   int                burst_left = 0;
   int                results_seen = 0;
   int                quiet_cycles = 0;
   int                hold_left = 0;
   bit                hold_done = 1'b0;
   int                mode_left = 0;
   stall_pattern_type ready_mode = READY_ALWAYS;
   logic [PIX_W-1:0]  uniform_grid [9];

   lbp_3x3_uniform_code dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code       (rsp_code),
      .rsp_frame_last (rsp_frame_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one beat and hold it until taken. Bursts of random length are
   // separated by random gaps; valid stays up across beats inside a burst.
   task automatic push_beat(input logic kind, input logic [PIX_W-1:0] pix, output bit closed);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_pixel <= pix;
      do @(posedge clock); while (req_ready !== 1'b1);
      closed = sb.take_beat(kind, pix);
   endtask

   // Drop valid, wait for every queued code to come back, then let the
   // pipeline go quiet so a csr write lands on an idle block.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(pixel_mix_type mix);
      case (mix)
         MIX_LOW:         return 8'($urandom_range(0, 3));
         MIX_SPARSE_ZERO: return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
         MIX_FLAT: begin
            // mostly a near-flat field, with the odd extreme
            if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            return 8'(98 + $urandom_range(0, 4));
         end
         default:         return 8'($urandom);
      endcase
   endfunction

   // Push out the trailing codes with a mix of drain and pixel beats.
   task automatic drain_frame(output int taken);
      bit closed;
      closed = 1'b0;
      taken = 0;
      while (!closed) begin
         push_beat(1'($urandom_range(0, 1)), 8'($urandom), closed);
         taken++;
      end
   endtask

   // Feed the rest of the current frame, sprinkling in drain beats that the
   // block must ignore while pixels are still due, then drain it.
   task automatic run_frame(input pixel_mix_type mix, output int taken);
      bit closed;
      int drained;
      closed = 1'b0;
      taken = 0;
      while (!closed && !sb.pixels_done()) begin
         if ($urandom_range(0, 24) == 0) begin
            push_beat(1'b1, 8'($urandom), closed);
         end else begin
            push_beat(1'b0, pick_pixel(mix), closed);
            taken++;
         end
      end
      if (!closed) begin
         drain_frame(drained);
         taken += drained;
      end
   endtask

   // Rewrite a random subset of the registers; upper data bits carry junk except on height writes.
   task automatic reshape_frame();
      logic [CSR_W-1:0] data;
      int r;
      if ($urandom_range(0, 1)) begin
         data = 16'($urandom);
         r = $urandom_range(0, 99);
         if (r < 5)       data[FW_W-1:0] = FW_W'($urandom_range(0, 1));
         else if (r < 85) data[FW_W-1:0] = FW_W'($urandom_range(2, 12));
         else             data[FW_W-1:0] = FW_W'($urandom_range(13, 80));
         write_csr(CSR_FRAME_WIDTH, data);
      end
      if ($urandom_range(0, 1)) begin
         r = $urandom_range(0, 9);
         data = (r == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom_range(2, 7));
         write_csr(CSR_FRAME_HEIGHT, data);
      end
      if ($urandom_range(0, 1)) write_csr(CSR_CODE_MODE, 16'($urandom));
      if ($urandom_range(0, 19) == 0) write_csr(CSR_SPARE, 16'($urandom));
   endtask

   // Check every code beat as it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         sb.check_beat(rsp_code, rsp_frame_last);
         results_seen++;
      end
   end

   // Receiver: cycle through stall patterns in stretches of random length.
   // Once, hold off for a long stretch so the block backs up into req_ready.
   always @(negedge clock) begin
      if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = stall_pattern_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready <= (mode_left % 4 == 0);
            default:      rsp_ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      bit closed;
      int taken;
      int random_beats;
      pixel_mix_type mix;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Basic codes on the smallest frame: width 0 and height 1 both clamp
      // to 2. A drain between pixels is dropped; pixel beats after the frame
      // is in act as drains.
      write_csr(CSR_FRAME_WIDTH, 16'd0);
      write_csr(CSR_FRAME_HEIGHT, 16'd1);
      write_csr(CSR_CODE_MODE, 16'(MODE_BASIC));
      push_beat(1'b0, 8'd0, closed);
      push_beat(1'b1, 8'hFF, closed);
      push_beat(1'b0, 8'd255, closed);
      push_beat(1'b0, 8'd128, closed);
      push_beat(1'b0, 8'd0, closed);
      push_beat(1'b0, 8'hFF, closed);
      drain_frame(taken);

      // Uniform mapping on a 3x3 frame: a cluster of zeros trips the zero
      // mark, a bright center leaves a single-bit pattern, the rest mixes.
      settle();
      write_csr(CSR_CODE_MODE, 16'(MODE_UNIFORM));
      write_csr(CSR_FRAME_WIDTH, 16'd3);
      write_csr(CSR_FRAME_HEIGHT, 16'd3);
      write_csr(CSR_SPARE, 16'hFFFF);
      uniform_grid = '{8'd0, 8'd0, 8'd5, 8'd7, 8'd255, 8'd1, 8'd255, 8'd3, 8'd9};
      foreach (uniform_grid[i]) push_beat(1'b0, uniform_grid[i], closed);
      drain_frame(taken);

      // Widest row: width 2047 clamps to the line store size, so the first
      // code leaves on the second beat after a full row. Stop with the column
      // counter past a new width of 4, so it wraps into the drain rows of a
      // frame whose height of 0 clamps to 2.
      settle();
      write_csr(CSR_FRAME_WIDTH, 16'hFFFF);
      write_csr(CSR_FRAME_HEIGHT, 16'hFFFF);
      repeat (WIDE_BEATS) push_beat(1'b0, pick_pixel(MIX_SPARSE_ZERO), closed);
      settle();
      write_csr(CSR_FRAME_WIDTH, 16'd4);
      write_csr(CSR_FRAME_HEIGHT, 16'd0);
      run_frame(MIX_SPARSE_ZERO, taken);

      // Registers rewritten mid-frame: start tall and 6 wide, stop with the
      // column counter past the new width of 4 so it wraps, then finish short.
      settle();
      write_csr(CSR_CODE_MODE, 16'(MODE_BASIC));
      write_csr(CSR_FRAME_WIDTH, 16'd6);
      write_csr(CSR_FRAME_HEIGHT, 16'hFFFF);
      repeat (29) push_beat(1'b0, pick_pixel(MIX_FULL), closed);
      settle();
      write_csr(CSR_FRAME_WIDTH, 16'd4);
      write_csr(CSR_FRAME_HEIGHT, 16'd7);
      run_frame(MIX_LOW, taken);

      // Random frames: new settings on most frame boundaries, back-to-back
      // frames otherwise.
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         if ($urandom_range(0, 9) < 7) begin
            settle();
            reshape_frame();
         end
         mix = pixel_mix_type'($urandom_range(0, 3));
         run_frame(mix, taken);
         random_beats += taken;
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.outstanding() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
